// File: design/cphc_pkg.sv
// shared constants, types and command codes of the half-plane clip core
package cphc_pkg;

  localparam int CW   = 48;          // coordinate width
  localparam int DW   = CW + 1;      // coordinate difference
  localparam int SW   = 2 * DW + 1;  // cross product, s1, s2
  localparam int DENW = SW + 1;      // s2 - s1
  localparam int AW   = CW + SW + 1; // accumulator and numerator
  localparam int TW   = 33;          // side tolerance
  localparam int IW   = 3;           // config index
  localparam int CNTW = $clog2(AW);

  localparam logic [IW-1:0] REG_START_X = 3'd0;
  localparam logic [IW-1:0] REG_START_Y = 3'd1;
  localparam logic [IW-1:0] REG_END_X   = 3'd2;
  localparam logic [IW-1:0] REG_END_Y   = 3'd3;
  localparam logic [IW-1:0] REG_KEEP    = 3'd4;
  localparam logic [IW-1:0] REG_TOL     = 3'd5;

  localparam logic [TW-1:0] TOL_RESET = 33'd4295;

  localparam logic [1:0] KIND_KEEP = 2'd0;
  localparam logic [1:0] KIND_XING = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  typedef enum logic [1:0] {
    OP_MUL_SET,
    OP_MUL_SUB,
    OP_DIV
  } mdu_op_t;

  typedef struct packed {
    logic    start;
    mdu_op_t op;
  } mdu_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mdu_sts_t;

endpackage

// File: design/cphc_mdu.sv
// shared shift-add multiply-accumulate and restoring divide unit
module cphc_mdu (
  input  logic                              clk,
  input  logic                              rst,
  input  cphc_pkg::mdu_cmd_t                cmd,
  input  logic signed [cphc_pkg::SW-1:0]    mcand,
  input  logic signed [cphc_pkg::DW-1:0]    mplier,
  input  logic signed [cphc_pkg::DENW-1:0]  den,
  output cphc_pkg::mdu_sts_t                sts,
  output logic signed [cphc_pkg::AW-1:0]    acc,
  output logic signed [cphc_pkg::CW-1:0]    quo
);
  import cphc_pkg::*;

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV} mstate_t;

  mstate_t           state;
  logic [CNTW-1:0]   cnt;
  logic [AW-1:0]     a_sh;
  logic [DW-1:0]     b_sh;
  logic              neg;
  logic              done;
  logic [AW-1:0]     nreg;
  logic [DENW-1:0]   rem;
  logic [DENW-1:0]   dmag;
  logic              qneg;
  logic              dzero;

  logic              msub;
  logic [AW-1:0]     acc_next;
  logic [DENW:0]     r2;
  logic [DENW:0]     rdiff;
  logic              ge;
  logic [DENW-1:0]   rem_next;
  logic [AW-1:0]     nreg_next;
  logic              q_hi;
  logic              q_msb;
  logic              q_low;
  logic [CW-1:0]     quo_next;

  // multiplier msb carries negative weight
  always_comb begin
    msub = neg ^ (cnt == CNTW'(DW - 1));
    acc_next = acc;
    if (b_sh[0]) begin
      acc_next = msub ? (acc - a_sh) : (acc + a_sh);
    end
  end

  always_comb begin
    r2        = {rem, nreg[AW-1]};
    rdiff     = r2 - {1'b0, dmag};
    ge        = (r2 >= {1'b0, dmag});
    rem_next  = ge ? rdiff[DENW-1:0] : r2[DENW-1:0];
    nreg_next = {nreg[AW-2:0], ge};
    q_hi      = |nreg_next[AW-1:CW];
    q_msb     = nreg_next[CW-1];
    q_low     = |nreg_next[CW-2:0];
    if (dzero) begin
      quo_next = '0;
    end else if (qneg) begin
      if (q_hi || (q_msb && q_low)) quo_next = {1'b1, {(CW-1){1'b0}}};
      else                          quo_next = -nreg_next[CW-1:0];
    end else begin
      if (q_hi || q_msb) quo_next = {1'b0, {(CW-1){1'b1}}};
      else               quo_next = nreg_next[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      unique case (state)
        M_IDLE: begin
          if (cmd.start) begin
            cnt <= '0;
            if (cmd.op == OP_DIV) begin
              nreg  <= acc[AW-1] ? -acc : acc;
              dmag  <= den[DENW-1] ? -den : den;
              qneg  <= acc[AW-1] ^ den[DENW-1];
              dzero <= (den == '0);
              rem   <= '0;
              state <= M_DIV;
            end else begin
              a_sh  <= {{(AW-SW){mcand[SW-1]}}, mcand};
              b_sh  <= mplier;
              neg   <= (cmd.op == OP_MUL_SUB);
              if (cmd.op == OP_MUL_SET) acc <= '0;
              state <= M_MUL;
            end
          end
        end
        M_MUL: begin
          acc  <= acc_next;
          a_sh <= {a_sh[AW-2:0], 1'b0};
          b_sh <= {1'b0, b_sh[DW-1:1]};
          cnt  <= cnt + 1'b1;
          if (cnt == CNTW'(DW - 1)) begin
            state <= M_IDLE;
            done  <= 1'b1;
          end
        end
        M_DIV: begin
          rem  <= rem_next;
          nreg <= nreg_next;
          cnt  <= cnt + 1'b1;
          if (cnt == CNTW'(AW - 1)) begin
            quo   <= quo_next;
            state <= M_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  assign sts.busy = (state != M_IDLE);
  assign sts.done = done;

endmodule

// File: design/convex_polygon_half_plane_clip_core.sv
// half-plane clipper for streamed convex polygon vertices
// one vertex at a time: in_stall stays high until all its results are loaded
// side test takes two serial products per vertex
// each crossing adds eight products and two divides
// the single multiply/divide unit runs them all in series; outputs sit in one register
// synchronous reset: line and tolerance to defaults, polygon state cleared
module convex_polygon_half_plane_clip_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cphc_pkg::IW-1:0]           cfg_index,
  input  logic [cphc_pkg::CW-1:0]           cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [cphc_pkg::CW-1:0]    vert_x,
  input  logic signed [cphc_pkg::CW-1:0]    vert_y,
  input  logic                              vert_last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [cphc_pkg::CW-1:0]    out_x,
  output logic signed [cphc_pkg::CW-1:0]    out_y,
  output logic [1:0]                        out_kind,
  output logic                              out_last
);
  import cphc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ISSUE, ST_WAIT, ST_CLASS, ST_EMIT_X, ST_KEEP, ST_END
  } state_t;

  typedef enum logic [3:0] {
    PC_SIDE0, PC_SIDE1, PC_S1A, PC_S1B, PC_S2A, PC_S2B,
    PC_NXA, PC_NXB, PC_DX, PC_NYA, PC_NYB, PC_DY
  } pc_t;

  state_t               state;
  pc_t                  pc;
  logic [CW-1:0]        sx, sy, ex, ey;
  logic                 keep;
  logic [TW-1:0]        tol;
  logic [CW-1:0]        vx, vy;
  logic                 vlast;
  logic [CW-1:0]        ax, ay, bx, by;
  logic [CW-1:0]        fx, fy, px, py;
  logic [1:0]           fside, pside, side;
  logic                 kept;
  logic                 have_prev;
  logic                 ret_end;
  logic [SW-1:0]        s1, s2;
  logic [CW-1:0]        qx, qy;
  logic                 cmd_start;

  mdu_cmd_t             cmd;
  mdu_sts_t             sts;
  logic signed [SW-1:0]   mcand;
  logic signed [DW-1:0]   mplier;
  logic signed [DENW-1:0] den;
  logic signed [AW-1:0]   acc;
  logic signed [CW-1:0]   quo;

  logic signed [SW-1:0] cval, tolx, ntolx;
  logic [1:0]           side_c;
  logic                 kept_c;
  logic [1:0]           fs_eff;
  logic                 can_load;

  function automatic logic signed [DW-1:0] diff(input logic [CW-1:0] a,
                                                input logic [CW-1:0] b);
    diff = {a[CW-1], a} - {b[CW-1], b};
  endfunction

  function automatic logic signed [SW-1:0] ext(input logic [DW-1:0] d);
    ext = {{(SW-DW){d[DW-1]}}, d};
  endfunction

  // side codes are {positive, negative}
  function automatic logic crosses(input logic [1:0] a, input logic [1:0] b);
    crosses = (a[1] && b[0]) || (a[0] && b[1]);
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sx   <= '0;
      sy   <= '0;
      ex   <= '0;
      ey   <= '0;
      keep <= 1'b0;
      tol  <= TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_X: sx   <= cfg_data;
        REG_START_Y: sy   <= cfg_data;
        REG_END_X:   ex   <= cfg_data;
        REG_END_Y:   ey   <= cfg_data;
        REG_KEEP:    keep <= cfg_data[0];
        REG_TOL:     tol  <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  // operand program of the shared unit
  always_comb begin
    mcand     = '0;
    mplier    = '0;
    cmd.start = cmd_start;
    cmd.op    = OP_MUL_SET;
    case (pc)
      PC_SIDE0: begin mcand = ext(diff(ex, sx)); mplier = diff(vy, sy); end
      PC_SIDE1: begin
        mcand = ext(diff(ey, sy)); mplier = diff(vx, sx); cmd.op = OP_MUL_SUB;
      end
      PC_S1A: begin mcand = ext(diff(bx, ax)); mplier = diff(sy, ay); end
      PC_S1B: begin
        mcand = ext(diff(by, ay)); mplier = diff(sx, ax); cmd.op = OP_MUL_SUB;
      end
      PC_S2A: begin mcand = ext(diff(bx, ax)); mplier = diff(ey, ay); end
      PC_S2B: begin
        mcand = ext(diff(by, ay)); mplier = diff(ex, ax); cmd.op = OP_MUL_SUB;
      end
      PC_NXA: begin mcand = s2; mplier = {sx[CW-1], sx}; end
      PC_NXB: begin mcand = s1; mplier = {ex[CW-1], ex}; cmd.op = OP_MUL_SUB; end
      PC_NYA: begin mcand = s2; mplier = {sy[CW-1], sy}; end
      PC_NYB: begin mcand = s1; mplier = {ey[CW-1], ey}; cmd.op = OP_MUL_SUB; end
      PC_DX, PC_DY: cmd.op = OP_DIV;
      default: ;
    endcase
  end

  assign den = {s2[SW-1], s2} - {s1[SW-1], s1};

  cphc_mdu u_mdu (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .mcand  (mcand),
    .mplier (mplier),
    .den    (den),
    .sts    (sts),
    .acc    (acc),
    .quo    (quo)
  );

  always_comb begin
    cval   = acc[SW-1:0];
    tolx   = {{(SW-TW){1'b0}}, tol};
    ntolx  = -tolx;
    side_c = {cval > tolx, cval < ntolx};
    kept_c = keep ? (cval < tolx) : (cval > ntolx);
    fs_eff = have_prev ? fside : side;
  end

  assign can_load = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    cmd_start <= 1'b0;
    if (out_valid && !out_stall) out_valid <= 1'b0;
    if (rst) begin
      state     <= ST_IDLE;
      pc        <= PC_SIDE0;
      out_valid <= 1'b0;
      have_prev <= 1'b0;
      cmd_start <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid && !in_stall) begin
            vx    <= vert_x;
            vy    <= vert_y;
            vlast <= vert_last;
            pc    <= PC_SIDE0;
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          cmd_start <= 1'b1;
          state     <= ST_WAIT;
        end
        ST_WAIT: begin
          if (sts.done) begin
            case (pc)
              PC_SIDE1: state <= ST_CLASS;
              PC_DY: begin
                qy    <= quo;
                state <= ST_EMIT_X;
              end
              default: begin
                if (pc == PC_S1B) s1 <= acc[SW-1:0];
                if (pc == PC_S2B) s2 <= acc[SW-1:0];
                if (pc == PC_DX)  qx <= quo;
                pc    <= pc_t'(pc + 4'd1);
                state <= ST_ISSUE;
              end
            endcase
          end
        end
        ST_CLASS: begin
          side <= side_c;
          kept <= kept_c;
          if (have_prev && crosses(pside, side_c)) begin
            ax      <= px;
            ay      <= py;
            bx      <= vx;
            by      <= vy;
            ret_end <= 1'b0;
            pc      <= PC_S1A;
            state   <= ST_ISSUE;
          end else begin
            state <= ST_KEEP;
          end
        end
        ST_EMIT_X: begin
          if (can_load) begin
            out_valid <= 1'b1;
            out_x     <= qx;
            out_y     <= qy;
            out_kind  <= KIND_XING;
            out_last  <= 1'b0;
            state     <= ret_end ? ST_END : ST_KEEP;
          end
        end
        ST_KEEP: begin
          if (!kept || can_load) begin
            if (kept) begin
              out_valid <= 1'b1;
              out_x     <= vx;
              out_y     <= vy;
              out_kind  <= KIND_KEEP;
              out_last  <= 1'b0;
            end
            if (!have_prev) begin
              fx    <= vx;
              fy    <= vy;
              fside <= side;
            end
            px        <= vx;
            py        <= vy;
            pside     <= side;
            have_prev <= 1'b1;
            if (!vlast) begin
              state <= ST_IDLE;
            end else if (crosses(side, fs_eff)) begin
              // closing edge back to the first vertex
              ax      <= vx;
              ay      <= vy;
              bx      <= fx;
              by      <= fy;
              ret_end <= 1'b1;
              pc      <= PC_S1A;
              state   <= ST_ISSUE;
            end else begin
              state <= ST_END;
            end
          end
        end
        ST_END: begin
          if (can_load) begin
            out_valid <= 1'b1;
            out_x     <= '0;
            out_y     <= '0;
            out_kind  <= KIND_END;
            out_last  <= 1'b1;
            have_prev <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_idle_unit_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !sts.busy)
    else $error("arith unit busy while idle");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    sts.done |-> (state == ST_WAIT))
    else $error("arith unit done outside wait");

  a_last_on_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_kind == KIND_END)))
    else $error("out_last does not match end marker");

  a_start_after_issue: assert property (@(posedge clk) disable iff (rst)
    cmd_start |-> ($past(state) == ST_ISSUE))
    else $error("unit start without issue");
`endif

endmodule

// File: tb/sv/tb_top.sv
// testbench of the half-plane clip core: scoreboard with its own exact predictor
module tb_top;
  import cphc_pkg::*;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [1:0]    kind;
    logic          last;
  } clip_point_t;

  class clip_scoreboard;
    logic [CW-1:0] s_x, s_y, e_x, e_y;
    logic          keep_right;
    logic [TW-1:0] tol;
    logic [CW-1:0] first_x, first_y, prev_x, prev_y;
    int            first_side, prev_side;
    bit            open_poly;
    clip_point_t   pending[$];
    int            errors;

    function new();
      s_x = '0; s_y = '0; e_x = '0; e_y = '0;
      keep_right = 1'b0; tol = TOL_RESET;
      first_x = '0; first_y = '0; prev_x = '0; prev_y = '0;
      first_side = 0; prev_side = 0; open_poly = 0; errors = 0;
    endfunction

    function void set_reg(logic [IW-1:0] idx, logic [CW-1:0] d);
      case (idx)
        REG_START_X: s_x = d;
        REG_START_Y: s_y = d;
        REG_END_X:   e_x = d;
        REG_END_Y:   e_y = d;
        REG_KEEP:    keep_right = d[0];
        REG_TOL:     tol = d[TW-1:0];
        default: ;
      endcase
    endfunction

    function void add_expected(clip_point_t p);
      pending.insert(pending.size(), p);
    endfunction

    function wide_t ext(logic [CW-1:0] v);
      wide_t w;
      w = $signed(v);
      return w;
    endfunction

    function logic [CW-1:0] clamp(wide_t v);
      wide_t hi, lo;
      hi = ext({1'b0, {(CW-1){1'b1}}});
      lo = ext({1'b1, {(CW-1){1'b0}}});
      if (v > hi) return hi[CW-1:0];
      if (v < lo) return lo[CW-1:0];
      return v[CW-1:0];
    endfunction

    function wide_t side_value(logic [CW-1:0] px, logic [CW-1:0] py);
      wide_t dx, dy;
      dx = ext(e_x) - ext(s_x);
      dy = ext(e_y) - ext(s_y);
      return dx * (ext(py) - ext(s_y)) - dy * (ext(px) - ext(s_x));
    endfunction

    // crossing of edge a->b with the line, quotient truncated toward zero
    function clip_point_t crossing(logic [CW-1:0] ax, logic [CW-1:0] ay,
                                   logic [CW-1:0] bx, logic [CW-1:0] by);
      wide_t ux, uy, s1, s2, den;
      clip_point_t p;
      ux = ext(bx) - ext(ax);
      uy = ext(by) - ext(ay);
      s1 = ux * (ext(s_y) - ext(ay)) - uy * (ext(s_x) - ext(ax));
      s2 = ux * (ext(e_y) - ext(ay)) - uy * (ext(e_x) - ext(ax));
      den = s2 - s1;
      p.kind = KIND_XING;
      p.last = 1'b0;
      if (den == 0) begin
        p.x = '0;
        p.y = '0;
      end else begin
        p.x = clamp((ext(s_x) * s2 - ext(e_x) * s1) / den);
        p.y = clamp((ext(s_y) * s2 - ext(e_y) * s1) / den);
      end
      return p;
    endfunction

    function void note_vertex(logic [CW-1:0] vx, logic [CW-1:0] vy, logic vlast);
      wide_t c, t;
      int side;
      clip_point_t p;
      c = side_value(vx, vy);
      t = wide_t'({1'b0, tol});
      side = (c < -t) ? -1 : ((c > t) ? 1 : 0);
      if (open_poly && prev_side * side < 0)
        add_expected(crossing(prev_x, prev_y, vx, vy));
      if (keep_right ? (c < t) : (c > -t)) begin
        p.x = vx; p.y = vy; p.kind = KIND_KEEP; p.last = 1'b0;
        add_expected(p);
      end
      if (!open_poly) begin
        first_x = vx; first_y = vy; first_side = side;
      end
      prev_x = vx; prev_y = vy; prev_side = side;
      open_poly = 1;
      if (vlast) begin
        if (side * first_side < 0)
          add_expected(crossing(vx, vy, first_x, first_y));
        p.x = '0; p.y = '0; p.kind = KIND_END; p.last = 1'b1;
        add_expected(p);
        open_poly = 0;
      end
    endfunction

    function void check_point(clip_point_t got);
      clip_point_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected output x=%h y=%h kind=%0d last=%b",
                   got.x, got.y, got.kind, got.last);
        return;
      end
      want = pending.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.kind !== want.kind ||
          got.last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected x=%h y=%h kind=%0d last=%b,",
                   want.x, want.y, want.kind, want.last,
                   " got x=%h y=%h kind=%0d last=%b",
                   got.x, got.y, got.kind, got.last);
      end
    endfunction
  endclass

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [IW-1:0] cfg_index;
  logic [CW-1:0] cfg_data;
  logic in_valid, in_stall;
  logic signed [CW-1:0] vert_x, vert_y;
  logic vert_last;
  logic out_valid, out_stall;
  logic signed [CW-1:0] out_x, out_y;
  logic [1:0] out_kind;
  logic out_last;

  clip_scoreboard sb;
  bit   no_gaps;
  int   vertex_count;
  int   idle_cycles;
  int   out_hold;
  const int SETTLE = 1600;
  const int WATCHDOG = 40000;

  convex_polygon_half_plane_clip_core DUT (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 9);
  endfunction

  function logic [CW-1:0] rand_coord();
    return CW'({$urandom, $urandom});
  endfunction

  // output side: check each transfer and draw the next stall
  always @(posedge clk) begin
    clip_point_t got;
    int n;
    if (rst) begin
      out_stall <= 1'b0;
      out_hold <= 0;
    end else if (out_valid && !out_stall) begin
      got.x = out_x; got.y = out_y; got.kind = out_kind; got.last = out_last;
      sb.check_point(got);
      n = draw_gap();
      out_hold <= n;
      out_stall <= (n != 0);
    end else if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      if (out_hold == 1) out_stall <= 1'b0;
    end
  end

  // cycles with no transfer on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [IW-1:0] idx, logic [CW-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, d);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_line(logic [CW-1:0] sx, logic [CW-1:0] sy, logic [CW-1:0] ex,
                          logic [CW-1:0] ey, logic keep, logic [TW-1:0] t);
    drain();
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_END_X, ex);
    write_reg(REG_END_Y, ey);
    write_reg(REG_KEEP, {{(CW-1){1'b0}}, keep});
    write_reg(REG_TOL, {{(CW-TW){1'b0}}, t});
  endtask

  task automatic send_vertex(logic [CW-1:0] x, logic [CW-1:0] y, logic lst);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    vert_x <= x;
    vert_y <= y;
    vert_last <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_vertex(x, y, lst);
    vertex_count++;
  endtask

  // convex octagon directions; any ordered subset stays convex
  int dir_x[8] = '{8, 6, 0, -6, -8, -6, 0, 6};
  int dir_y[8] = '{0, 6, 8, 6, 0, -6, -8, -6};

  task automatic send_polygon(logic signed [CW-1:0] cx, logic signed [CW-1:0] cy);
    logic signed [CW-1:0] r;
    int n, k, start, step;
    bit broken;
    r = CW'($urandom_range(1 << 4, 1 << 30));
    n = $urandom_range(1, 8);
    start = $urandom_range(0, 7);
    step = $urandom_range(0, 1) ? 1 : 7;
    broken = ($urandom_range(0, 19) == 0);
    k = 0;
    for (int i = 0; i < 8 && k < n; i++) begin
      if (i != 0 && n < 8 && $urandom_range(0, 8 - n) != 0) continue;
      k++;
      send_vertex(cx + r * dir_x[(start + step * i) % 8],
                  cy + r * dir_y[(start + step * i) % 8], k == n && !broken);
    end
    if (k < n || broken) send_vertex(cx, cy, 1'b1);
  endtask

  initial begin
    logic signed [CW-1:0] cx, cy, sx, sy;
    logic [TW-1:0] t;
    int pick;
    sb = new();
    rst = 1'b1;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; vert_x = '0; vert_y = '0; vert_last = 1'b0;
    no_gaps = 0; vertex_count = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: degenerate line keeps everything
    send_vertex({1'b0, {(CW-1){1'b1}}}, {1'b1, {(CW-1){1'b0}}}, 1'b0);
    send_vertex({1'b1, {(CW-1){1'b0}}}, {1'b0, {(CW-1){1'b1}}}, 1'b1);
    send_vertex('0, '0, 1'b1);

    // x axis, zero tolerance: crossings, closing edge, vertex on the line
    set_line('0, '0, 48'sh1_0000, '0, 1'b0, '0);
    send_vertex(48'sh5_0000, 48'sh5_0000, 1'b0);
    send_vertex(-48'sh5_0000, -48'sh3_0000, 1'b0);
    send_vertex(48'sh7_0000, -48'sh1_0000, 1'b1);
    send_vertex(48'sh1_0000, '0, 1'b0);
    send_vertex(48'sh2_0000, 48'sh1, 1'b0);
    send_vertex(48'sh3_0000, -48'sh1, 1'b1);
    send_vertex(48'sh9_0000, -48'sh9_0000, 1'b1);
    send_vertex({1'b0, {(CW-1){1'b1}}}, {1'b0, {(CW-1){1'b1}}}, 1'b0);
    send_vertex({1'b1, {(CW-1){1'b0}}}, {1'b1, {(CW-1){1'b0}}}, 1'b1);

    // keep right with tolerance 2^32, the largest that the bench uses
    set_line(48'sh3_0000, -48'sh2_0000, -48'sh4_0000, 48'sh7_0000, 1'b1, {1'b1, 32'h0});
    send_vertex('0, '0, 1'b0);
    send_vertex(48'sh10_0000, 48'sh10_0000, 1'b0);
    send_vertex(-48'sh10_0000, -48'sh10_0000, 1'b1);
    send_vertex({1'b0, {(CW-1){1'b1}}}, '0, 1'b0);
    send_vertex({1'b1, {(CW-1){1'b0}}}, '0, 1'b1);

    while (vertex_count < 130) begin
      cx = $signed(rand_coord()) >>> $urandom_range(9, 16);
      cy = $signed(rand_coord()) >>> $urandom_range(9, 16);
      sx = cx + ($signed(rand_coord()) >>> 20);
      sy = cy + ($signed(rand_coord()) >>> 20);
      pick = $urandom_range(0, 3);
      t = pick == 0 ? '0 : pick == 1 ? TOL_RESET : pick == 2 ? {1'b1, 32'h0} :
          {1'b0, $urandom};
      set_line(sx, sy, sx + ($signed(rand_coord()) >>> $urandom_range(14, 40)),
               sy + ($signed(rand_coord()) >>> $urandom_range(14, 40)),
               1'($urandom_range(0, 1)), t);
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(3, 6)) begin
        if ($urandom_range(0, 5) == 0) begin
          repeat ($urandom_range(0, 3)) send_vertex(rand_coord(), rand_coord(), 1'b0);
          send_vertex(rand_coord(), rand_coord(), 1'b1);
        end else begin
          send_polygon(sx + ($signed(rand_coord()) >>> 17),
                       sy + ($signed(rand_coord()) >>> 17));
        end
        if ($urandom_range(0, 7) == 0) begin
          in_valid <= 1'b0;
          while (sb.pending.size() != 0) @(posedge clk);
        end
      end
    end

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
